// File: sv/dmx_fixture_channel_mapper_assert.svh
// Assertion helpers for the DMX channel mapper. Each macro expects clk and rst_n
// in the scope where it is used.
`ifndef DMX_FIXTURE_CHANNEL_MAPPER_ASSERT_SVH
`define DMX_FIXTURE_CHANNEL_MAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMXCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmx channel mapper check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMXCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmx channel mapper check failed");

`endif

// File: sv/dmxcm_pkg.sv
package dmxcm_pkg;

    localparam int UNIVERSE_SLOTS_DEF = 512;

    localparam int SLOT_W     = 10;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int KELVIN_W   = 16;
    localparam int UNIT_W     = 17;
    localparam int HUE_W      = 15;

    // Shared divider: nine quotient bits, the top one only flags saturation.
    localparam int DIV_STEPS = 9;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_STEPS - 1;

    localparam int HUE_ROUND = 23040;
    localparam int HUE_DEN   = 46080;

    localparam logic [LEVEL_W-1:0] MODE_TEMP_BYTE = 8'd16;
    localparam logic [LEVEL_W-1:0] MODE_HSI_BYTE  = 8'd48;
    localparam logic [LEVEL_W-1:0] NEUTRAL_TINT   = 8'd128;
    localparam logic [LEVEL_W-1:0] OFFSET_UNUSED  = 8'd255;

    typedef enum logic [1:0] {
        CMD_RENDER = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2
    } dmxcm_cmd_t;

    typedef enum logic [1:0] {
        PROF_FOUR     = 2'd0,
        PROF_DIM_TEMP = 2'd1,
        PROF_CUSTOM   = 2'd2
    } dmxcm_prof_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE     = 3'd0,
        REG_TEMP_MIN = 3'd1,
        REG_TEMP_MAX = 3'd2,
        REG_PROFILE  = 3'd3,
        REG_DIM_OFF  = 3'd4,
        REG_TEMP_OFF = 3'd5,
        REG_HUE_OFF  = 3'd6,
        REG_SAT_OFF  = 3'd7
    } dmxcm_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_CCT,
        ST_HUE,
        ST_WRITE,
        ST_READ,
        ST_READ_OUT
    } dmxcm_state_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [SLOT_W-1:0]   slot_index;
        logic [LEVEL_W-1:0]  slot_value;
        logic [UNIT_W-1:0]   intensity;
        logic [KELVIN_W-1:0] temp_kelvin;
        logic [HUE_W-1:0]    hue_angle;
        logic [UNIT_W-1:0]   saturation;
        logic                use_hsi;
    } dmxcm_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } dmxcm_div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } dmxcm_div_rsp_t;

endpackage

// File: sv/dmxcm_if.sv
interface dmxcm_item_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          command;
    logic [dmxcm_pkg::SLOT_W-1:0]        slot_index;
    logic [dmxcm_pkg::LEVEL_W-1:0]       slot_value;
    logic [dmxcm_pkg::UNIT_W-1:0]        intensity;
    logic [dmxcm_pkg::KELVIN_W-1:0]      temp_kelvin;
    logic [dmxcm_pkg::HUE_W-1:0]         hue_angle;
    logic [dmxcm_pkg::UNIT_W-1:0]        saturation;
    logic                                use_hsi;

    modport source (
        output valid, command, slot_index, slot_value, intensity, temp_kelvin,
               hue_angle, saturation, use_hsi,
        input  ready
    );
    modport sink (
        input  valid, command, slot_index, slot_value, intensity, temp_kelvin,
               hue_angle, saturation, use_hsi,
        output ready
    );
endinterface

interface dmxcm_result_if;
    logic                          valid;
    logic                          ready;
    logic [dmxcm_pkg::SLOT_W-1:0]  slot_number;
    logic [dmxcm_pkg::LEVEL_W-1:0] slot_level;
    logic                          final_flag;

    modport source (
        output valid, slot_number, slot_level, final_flag,
        input  ready
    );
    modport sink (
        input  valid, slot_number, slot_level, final_flag,
        output ready
    );
endinterface

interface dmxcm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dmxcm_pkg::CFG_IDX_W-1:0]  index;
    logic [dmxcm_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: sv/dmx_fixture_channel_mapper.sv
// DMX fixture channel mapper. Keeps a universe of UNIVERSE_SLOTS data slots in a
// block RAM (slot 0, the start code, always reads 0) and turns render items
// into up to four slot writes, each reported as one result beat; raw items
// write one slot and read items return one. After reset a clearing pass zeroes
// every RAM word, during which no item is accepted (configuration writes are
// always taken). Items are handled one at a time. A render item moves through
// a prepare state, two runs of the shared 9-step divider (color temperature,
// then hue), a walk of the four-entry write list up to the last slot written
// (all four entries when nothing is written), and a return to idle. A raw write
// goes through the write state (walking all four entries when it is dropped)
// and a read through a RAM read state and an output state; the result side can
// stall writes and reads alike. The last result beat of an item sits in the
// output register while the next item is accepted.
module dmx_fixture_channel_mapper #(
    parameter int UNIVERSE_SLOTS = dmxcm_pkg::UNIVERSE_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dmxcm_item_if.sink            item,
    dmxcm_result_if.source        result,
    dmxcm_cfg_if.sink             cfg
);

    localparam int DEPTH   = UNIVERSE_SLOTS + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int ENTRIES = 4;
    localparam int SLOT_W  = dmxcm_pkg::SLOT_W;
    localparam int LVL_W   = dmxcm_pkg::LEVEL_W;
    localparam int NUM_W   = dmxcm_pkg::DIV_NUM_W;
    localparam int DEN_W   = dmxcm_pkg::DIV_DEN_W;
    localparam int KW      = dmxcm_pkg::KELVIN_W;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(UNIVERSE_SLOTS);
    localparam logic [NUM_W-1:0] UNIT_HALF = NUM_W'(32768);

    function automatic logic [LVL_W-1:0] unit_level(input logic [dmxcm_pkg::UNIT_W-1:0] x);
        logic [NUM_W-1:0] scaled;
        scaled = {x, 8'b0} - {8'b0, x} + UNIT_HALF;
        return scaled[NUM_W-1] ? '1 : scaled[NUM_W-2:NUM_W-9];
    endfunction

    // Control.
    dmxcm_pkg::dmxcm_state_t state_reg, state_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [1:0]              idx_reg, idx_next;
    logic                    cct_zero_reg, cct_zero_next;
    logic                    clearing;
    logic                    div_wait;

    // Item and computed levels.
    dmxcm_pkg::dmxcm_item_t  item_reg, item_next;
    logic [LVL_W-1:0]        dim_reg, dim_next;
    logic [LVL_W-1:0]        sat_reg, sat_next;
    logic [LVL_W-1:0]        hue_reg, hue_next;
    logic [LVL_W-1:0]        cct_reg, cct_next;

    // Configuration registers.
    logic [SLOT_W-1:0]       base_reg, base_next;
    logic [KW-1:0]           tmin_reg, tmin_next;
    logic [KW-1:0]           tmax_reg, tmax_next;
    logic [1:0]              prof_reg, prof_next;
    logic [LVL_W-1:0]        dim_off_reg, dim_off_next;
    logic [LVL_W-1:0]        temp_off_reg, temp_off_next;
    logic [LVL_W-1:0]        hue_off_reg, hue_off_next;
    logic [LVL_W-1:0]        sat_off_reg, sat_off_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic [LVL_W-1:0]        out_level_reg, out_level_next;
    logic                    out_final_reg, out_final_next;
    logic                    out_free;
    logic                    out_load;

    // Write list of the current item.
    logic [LVL_W-1:0]        ent_off [ENTRIES];
    logic [LVL_W-1:0]        ent_lvl [ENTRIES];
    logic [SLOT_W:0]         ent_slot [ENTRIES];
    logic [ENTRIES-1:0]      ent_use;
    logic [ENTRIES-1:0]      ent_ok;
    logic [ENTRIES-1:0]      ent_later;
    logic [ENTRIES-1:0]      ent_last;
    logic                    read_ok;

    // Divider operands.
    logic [KW-1:0]           tdiff;
    logic [KW-1:0]           span;
    logic [NUM_W-1:0]        cct_num;
    logic [NUM_W-1:0]        hue_num;
    dmxcm_pkg::dmxcm_div_req_t div_req;
    dmxcm_pkg::dmxcm_div_rsp_t div_rsp;

    // RAM port.
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [LVL_W-1:0]        ram_wdata;
    logic [LVL_W-1:0]        ram_rdata;

    dmxcm_ram #(
        .WIDTH (LVL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (item_reg.slot_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    dmxcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign tdiff   = item_reg.temp_kelvin - tmin_reg;
    assign span    = tmax_reg - tmin_reg;
    assign cct_num = {tdiff, 9'b0} - {8'b0, tdiff, 1'b0} + {9'b0, span};
    assign hue_num = {1'b0, item_reg.hue_angle, 9'b0} - {9'b0, item_reg.hue_angle, 1'b0}
                   + NUM_W'(dmxcm_pkg::HUE_ROUND);

    assign read_ok = (item_reg.slot_index != '0) && ({1'b0, item_reg.slot_index} <= SLOT_LIMIT);

    always_comb
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            ent_off[k] = LVL_W'(k);
            ent_lvl[k] = '0;
        end
        ent_use = '0;
        unique case (prof_reg)
            dmxcm_pkg::PROF_FOUR:
            begin
                ent_use    = '1;
                ent_lvl[0] = item_reg.use_hsi ? dmxcm_pkg::MODE_HSI_BYTE
                                              : dmxcm_pkg::MODE_TEMP_BYTE;
                ent_lvl[1] = dim_reg;
                ent_lvl[2] = item_reg.use_hsi ? hue_reg : cct_reg;
                ent_lvl[3] = item_reg.use_hsi ? sat_reg : dmxcm_pkg::NEUTRAL_TINT;
            end
            dmxcm_pkg::PROF_DIM_TEMP:
            begin
                ent_use[0] = 1'b1;
                ent_use[1] = 1'b1;
                ent_lvl[0] = dim_reg;
                ent_lvl[1] = cct_reg;
            end
            dmxcm_pkg::PROF_CUSTOM:
            begin
                ent_off[0] = dim_off_reg;
                ent_off[1] = temp_off_reg;
                ent_off[2] = hue_off_reg;
                ent_off[3] = sat_off_reg;
                ent_use[0] = dim_off_reg != dmxcm_pkg::OFFSET_UNUSED;
                ent_use[1] = temp_off_reg != dmxcm_pkg::OFFSET_UNUSED;
                ent_use[2] = item_reg.use_hsi && (hue_off_reg != dmxcm_pkg::OFFSET_UNUSED);
                ent_use[3] = item_reg.use_hsi && (sat_off_reg != dmxcm_pkg::OFFSET_UNUSED);
                ent_lvl[0] = dim_reg;
                ent_lvl[1] = cct_reg;
                ent_lvl[2] = hue_reg;
                ent_lvl[3] = sat_reg;
            end
            default:
            begin
                ent_use = '0;
            end
        endcase

        for (int k = 0; k < ENTRIES; k++)
        begin
            ent_slot[k] = {1'b0, base_reg} + {3'b0, ent_off[k]};
        end

        // A raw write is a one-entry list.
        if (item_reg.command == dmxcm_pkg::CMD_WRITE)
        begin
            ent_use     = ENTRIES'(1);
            ent_slot[0] = {1'b0, item_reg.slot_index};
            ent_lvl[0]  = item_reg.slot_value;
        end

        for (int k = 0; k < ENTRIES; k++)
        begin
            ent_ok[k] = ent_use[k] && (ent_slot[k] != '0) && (ent_slot[k] <= SLOT_LIMIT);
        end

        ent_later[ENTRIES-1] = 1'b0;
        for (int k = ENTRIES - 2; k >= 0; k--)
        begin
            ent_later[k] = ent_later[k+1] | ent_ok[k+1];
        end
        ent_last = ent_ok & ~ent_later;
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        cct_zero_next  = cct_zero_reg;
        item_next      = item_reg;
        dim_next       = dim_reg;
        sat_next       = sat_reg;
        hue_next       = hue_reg;
        cct_next       = cct_reg;
        out_load       = 1'b0;
        out_slot_next  = out_slot_reg;
        out_level_next = out_level_reg;
        out_final_next = out_final_reg;
        ram_we         = 1'b0;
        ram_waddr      = ent_slot[idx_reg][AW-1:0];
        ram_wdata      = ent_lvl[idx_reg];
        div_req.start  = 1'b0;
        div_req.num    = cct_num;
        div_req.den    = {span, 1'b0};

        unique case (state_reg)
            dmxcm_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = dmxcm_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            dmxcm_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    item_next.command     = item.command;
                    item_next.slot_index  = item.slot_index;
                    item_next.slot_value  = item.slot_value;
                    item_next.intensity   = item.intensity;
                    item_next.temp_kelvin = item.temp_kelvin;
                    item_next.hue_angle   = item.hue_angle;
                    item_next.saturation  = item.saturation;
                    item_next.use_hsi     = item.use_hsi;
                    idx_next              = '0;
                    unique case (item.command)
                        dmxcm_pkg::CMD_RENDER: state_next = dmxcm_pkg::ST_PREP;
                        dmxcm_pkg::CMD_WRITE:  state_next = dmxcm_pkg::ST_WRITE;
                        dmxcm_pkg::CMD_READ:   state_next = dmxcm_pkg::ST_READ;
                        default:               state_next = dmxcm_pkg::ST_IDLE;
                    endcase
                end
            end
            dmxcm_pkg::ST_PREP:
            begin
                dim_next      = unit_level(item_reg.intensity);
                sat_next      = unit_level(item_reg.saturation);
                cct_zero_next = !((tmax_reg > tmin_reg) && (item_reg.temp_kelvin > tmin_reg));
                div_req.start = 1'b1;
                state_next    = dmxcm_pkg::ST_CCT;
            end
            dmxcm_pkg::ST_CCT:
            begin
                if (div_rsp.done)
                begin
                    cct_next      = cct_zero_reg ? '0 : div_rsp.level;
                    div_req.start = 1'b1;
                    div_req.num   = hue_num;
                    div_req.den   = DEN_W'(dmxcm_pkg::HUE_DEN);
                    state_next    = dmxcm_pkg::ST_HUE;
                end
            end
            dmxcm_pkg::ST_HUE:
            begin
                if (div_rsp.done)
                begin
                    hue_next   = div_rsp.level;
                    idx_next   = '0;
                    state_next = dmxcm_pkg::ST_WRITE;
                end
            end
            dmxcm_pkg::ST_WRITE:
            begin
                if (!ent_ok[idx_reg])
                begin
                    if (idx_reg == 2'(ENTRIES - 1))
                    begin
                        state_next = dmxcm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    ram_we         = 1'b1;
                    out_slot_next  = ent_slot[idx_reg][SLOT_W-1:0];
                    out_level_next = ent_lvl[idx_reg];
                    out_final_next = ent_last[idx_reg];
                    if (ent_last[idx_reg])
                    begin
                        state_next = dmxcm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            dmxcm_pkg::ST_READ:
            begin
                state_next = dmxcm_pkg::ST_READ_OUT;
            end
            dmxcm_pkg::ST_READ_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_slot_next  = item_reg.slot_index;
                    out_level_next = read_ok ? ram_rdata : '0;
                    out_final_next = 1'b1;
                    state_next     = dmxcm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        base_next     = base_reg;
        tmin_next     = tmin_reg;
        tmax_next     = tmax_reg;
        prof_next     = prof_reg;
        dim_off_next  = dim_off_reg;
        temp_off_next = temp_off_reg;
        hue_off_next  = hue_off_reg;
        sat_off_next  = sat_off_reg;
        if (cfg.valid)
        begin
            unique case (dmxcm_pkg::dmxcm_reg_t'(cfg.index))
                dmxcm_pkg::REG_BASE:     base_next     = cfg.data[SLOT_W-1:0];
                dmxcm_pkg::REG_TEMP_MIN: tmin_next     = cfg.data[KW-1:0];
                dmxcm_pkg::REG_TEMP_MAX: tmax_next     = cfg.data[KW-1:0];
                dmxcm_pkg::REG_PROFILE:  prof_next     = cfg.data[1:0];
                dmxcm_pkg::REG_DIM_OFF:  dim_off_next  = cfg.data[LVL_W-1:0];
                dmxcm_pkg::REG_TEMP_OFF: temp_off_next = cfg.data[LVL_W-1:0];
                dmxcm_pkg::REG_HUE_OFF:  hue_off_next  = cfg.data[LVL_W-1:0];
                dmxcm_pkg::REG_SAT_OFF:  sat_off_next  = cfg.data[LVL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmxcm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            cct_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= SLOT_W'(1);
            tmin_reg      <= KW'(2700);
            tmax_reg      <= KW'(6500);
            prof_reg      <= dmxcm_pkg::PROF_FOUR;
            dim_off_reg   <= LVL_W'(0);
            temp_off_reg  <= LVL_W'(1);
            hue_off_reg   <= dmxcm_pkg::OFFSET_UNUSED;
            sat_off_reg   <= dmxcm_pkg::OFFSET_UNUSED;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            idx_reg       <= idx_next;
            cct_zero_reg  <= cct_zero_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            tmin_reg      <= tmin_next;
            tmax_reg      <= tmax_next;
            prof_reg      <= prof_next;
            dim_off_reg   <= dim_off_next;
            temp_off_reg  <= temp_off_next;
            hue_off_reg   <= hue_off_next;
            sat_off_reg   <= sat_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        dim_reg       <= dim_next;
        sat_reg       <= sat_next;
        hue_reg       <= hue_next;
        cct_reg       <= cct_next;
        out_slot_reg  <= out_slot_next;
        out_level_reg <= out_level_next;
        out_final_reg <= out_final_next;
    end

    assign item.ready         = (state_reg == dmxcm_pkg::ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.slot_number = out_slot_reg;
    assign result.slot_level  = out_level_reg;
    assign result.final_flag  = out_final_reg;

    assign clearing = (state_reg == dmxcm_pkg::ST_CLEAR);
    assign div_wait = (state_reg == dmxcm_pkg::ST_CCT) || (state_reg == dmxcm_pkg::ST_HUE);

`include "dmx_fixture_channel_mapper_assert.svh"

    // The store is written only by the clearing pass or together with a result beat.
    `DMXCM_ASSERT_NOW(a_store_write_reported, ram_we, clearing || out_load)
    // The divider only finishes while the sequencer waits for it.
    `DMXCM_ASSERT_NOW(a_div_done_expected, div_rsp.done, div_wait)
    // Loading the last beat of an item returns the sequencer to idle, which frees the input side.
    `DMXCM_ASSERT_NEXT(a_final_frees_input, out_load && out_final_next, item.ready)
    // Nothing moves on either channel while the store is being cleared.
    `DMXCM_ASSERT_NOW(a_quiet_clear, clearing, !item.ready && !result.valid)

endmodule

// File: sv/dmxcm_ram.sv
module dmxcm_ram #(
    parameter int WIDTH = dmxcm_pkg::LEVEL_W,
    parameter int DEPTH = dmxcm_pkg::UNIVERSE_SLOTS_DEF + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/dmxcm_div.sv
module dmxcm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dmxcm_pkg::dmxcm_div_req_t req,
    output dmxcm_pkg::dmxcm_div_rsp_t rsp
);

    localparam int STEPS  = dmxcm_pkg::DIV_STEPS;
    localparam int NUM_W  = dmxcm_pkg::DIV_NUM_W;
    localparam int STEP_W = $clog2(STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [STEPS-1:0]  quo_reg, quo_next;
    logic              fits;

    // One restoring step per cycle; the divisor register walks right instead of
    // a variable shift.
    assign fits = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(STEPS - 1);
            rem_next  = req.num;
            dsh_next  = {req.den, {(STEPS - 1){1'b0}}};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next  = dsh_reg >> 1;
            quo_next  = {quo_reg[STEPS-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    // A set top bit means the quotient reached 256 or more.
    assign rsp.done  = done_reg;
    assign rsp.level = quo_reg[STEPS-1] ? '1 : quo_reg[STEPS-2:0];

endmodule

// File: tb/sv/dmx_fixture_channel_mapper_tb.sv
module dmx_fixture_channel_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmxcm_pkg::*;

    localparam int SLOTS = UNIVERSE_SLOTS_DEF;
    localparam longint unsigned UNIT_SCALE = 65536;
    localparam longint unsigned HUE_TURN = 23040;
    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam logic [1:0] PROF_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam int SETTLE_LIMIT = 20000;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 31;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_number;
        logic [LEVEL_W-1:0] slot_level;
        logic               final_flag;
    } slot_report_t;

    typedef struct {
        dmxcm_item_t            item;
        int                     n_known;
        slot_report_t [3:0]     known;
    } directed_row_t;

    localparam slot_report_t NO_REPORT = '0;

    logic clk;
    logic rst_n;

    dmxcm_item_if   item_ch ();
    dmxcm_result_if result_ch ();
    dmxcm_cfg_if    cfg_ch ();

    dmx_fixture_channel_mapper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Shadow copy of the universe and of the fixture registers.
    logic [LEVEL_W-1:0]  shadow_universe [0:SLOTS];
    logic [SLOT_W-1:0]   fixture_base = 10'd1;
    logic [KELVIN_W-1:0] kelvin_lo = 16'd2700;
    logic [KELVIN_W-1:0] kelvin_hi = 16'd6500;
    logic [1:0]          fixture_profile = PROF_FOUR;
    logic [7:0]          off_dim = 8'd0;
    logic [7:0]          off_temp = 8'd1;
    logic [7:0]          off_hue = 8'd255;
    logic [7:0]          off_sat = 8'd255;

    slot_report_t pending_reports [$];
    slot_report_t item_reports [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int failures = 0;

    function automatic logic [7:0] rounded_level(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = (64'd2 * num + den) / (64'd2 * den);
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic void store_slot(int slot, logic [7:0] level);
        slot_report_t r;
        if (slot >= 1 && slot <= SLOTS)
        begin
            shadow_universe[slot] = level;
            r.slot_number = slot[SLOT_W-1:0];
            r.slot_level = level;
            r.final_flag = 1'b0;
            item_reports.push_back(r);
        end
    endfunction

    function automatic void place_level(logic [7:0] offset, logic [7:0] level);
        if (offset != OFFSET_UNUSED)
            store_slot(int'(fixture_base) + int'(offset), level);
    endfunction

    // Fills item_reports with the slot beats one item should produce.
    function automatic void predict_slot_writes(dmxcm_item_t it);
        logic [7:0] dim;
        logic [7:0] sat;
        logic [7:0] hue;
        logic [7:0] cct;
        slot_report_t r;
        item_reports.delete();
        dim = rounded_level(64'(it.intensity) * 64'd255, UNIT_SCALE);
        sat = rounded_level(64'(it.saturation) * 64'd255, UNIT_SCALE);
        hue = rounded_level(64'(it.hue_angle) * 64'd255, HUE_TURN);
        cct = 8'd0;
        if (kelvin_hi > kelvin_lo && it.temp_kelvin > kelvin_lo)
            cct = rounded_level(64'(it.temp_kelvin - kelvin_lo) * 64'd255,
                                64'(kelvin_hi - kelvin_lo));
        case (it.command)
            CMD_RENDER:
            begin
                case (fixture_profile)
                    PROF_FOUR:
                    begin
                        if (it.use_hsi)
                        begin
                            place_level(8'd0, MODE_HSI_BYTE);
                            place_level(8'd1, dim);
                            place_level(8'd2, hue);
                            place_level(8'd3, sat);
                        end
                        else
                        begin
                            place_level(8'd0, MODE_TEMP_BYTE);
                            place_level(8'd1, dim);
                            place_level(8'd2, cct);
                            place_level(8'd3, NEUTRAL_TINT);
                        end
                    end
                    PROF_DIM_TEMP:
                    begin
                        place_level(8'd0, dim);
                        place_level(8'd1, cct);
                    end
                    PROF_CUSTOM:
                    begin
                        place_level(off_dim, dim);
                        place_level(off_temp, cct);
                        if (it.use_hsi)
                        begin
                            place_level(off_hue, hue);
                            place_level(off_sat, sat);
                        end
                    end
                    default: ;
                endcase
            end
            CMD_WRITE: store_slot(int'(it.slot_index), it.slot_value);
            CMD_READ:
            begin
                r.slot_number = it.slot_index;
                r.slot_level = 8'd0;
                r.final_flag = 1'b0;
                if (it.slot_index >= 1 && it.slot_index <= SLOTS)
                    r.slot_level = shadow_universe[it.slot_index];
                item_reports.push_back(r);
            end
            default: ;
        endcase
        if (item_reports.size() > 0)
            item_reports[item_reports.size()-1].final_flag = 1'b1;
    endfunction

    function automatic dmxcm_item_t pack_item(logic [1:0] cmd, int slot, int value, int inten,
                                              int tk, int hue, int sat, bit hsi);
        dmxcm_item_t it;
        it.command = cmd;
        it.slot_index = SLOT_W'(slot);
        it.slot_value = LEVEL_W'(value);
        it.intensity = UNIT_W'(inten);
        it.temp_kelvin = KELVIN_W'(tk);
        it.hue_angle = HUE_W'(hue);
        it.saturation = UNIT_W'(sat);
        it.use_hsi = hsi;
        return it;
    endfunction

    function automatic slot_report_t slot_report(int slot, int level, bit last);
        slot_report_t r;
        r.slot_number = SLOT_W'(slot);
        r.slot_level = LEVEL_W'(level);
        r.final_flag = last;
        return r;
    endfunction

    function automatic directed_row_t table_row(dmxcm_item_t it, int n, slot_report_t b0,
                                                slot_report_t b1, slot_report_t b2,
                                                slot_report_t b3);
        directed_row_t row;
        row.item = it;
        row.n_known = n;
        row.known[0] = b0;
        row.known[1] = b1;
        row.known[2] = b2;
        row.known[3] = b3;
        return row;
    endfunction

    function automatic logic [UNIT_W-1:0] random_unit();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'd131071;
            default: return UNIT_W'($urandom_range(0, 131071));
        endcase
    endfunction

    // Mostly renders; reads lean toward the fixture's own slots so that the
    // levels just written get read back.
    function automatic dmxcm_item_t random_item();
        dmxcm_item_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            it.command = CMD_RENDER;
        else if (pick < 78)
            it.command = CMD_WRITE;
        else if (pick < 97)
            it.command = CMD_READ;
        else
            it.command = CMD_IGNORED;
        case ($urandom_range(9))
            0: it.slot_index = SLOT_W'($urandom_range(513, 1023));
            1: it.slot_index = '0;
            2, 3, 4: it.slot_index = SLOT_W'(int'(fixture_base) + $urandom_range(0, 8));
            default: it.slot_index = SLOT_W'($urandom_range(1, SLOTS));
        endcase
        it.slot_value = LEVEL_W'($urandom());
        it.intensity = random_unit();
        it.saturation = random_unit();
        case ($urandom_range(3))
            0: it.temp_kelvin = kelvin_lo + KELVIN_W'($urandom_range(0, 2));
            1: it.temp_kelvin = kelvin_hi - KELVIN_W'($urandom_range(0, 2));
            default: it.temp_kelvin = KELVIN_W'($urandom());
        endcase
        it.hue_angle = HUE_W'($urandom_range(0, 23040));
        it.use_hsi = 1'($urandom());
        return it;
    endfunction

    task automatic send_item(input dmxcm_item_t it, input int n_known,
                             input slot_report_t [3:0] known);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= it.command;
        item_ch.slot_index  <= it.slot_index;
        item_ch.slot_value  <= it.slot_value;
        item_ch.intensity   <= it.intensity;
        item_ch.temp_kelvin <= it.temp_kelvin;
        item_ch.hue_angle   <= it.hue_angle;
        item_ch.saturation  <= it.saturation;
        item_ch.use_hsi     <= it.use_hsi;
        do @(posedge clk); while (!item_ch.ready);
        predict_slot_writes(it);
        if (n_known < 0)
        begin
            foreach (item_reports[i])
                pending_reports.push_back(item_reports[i]);
        end
        else
        begin
            for (int i = 0; i < n_known; i++)
                pending_reports.push_back(known[i]);
        end
    endtask

    // Writes all eight registers back to back; the valid stays high between beats.
    task automatic program_fixture(input logic [15:0] setting [8]);
        for (int r = 0; r < 8; r++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= dmxcm_reg_t'(r);
            cfg_ch.data  <= setting[r];
            do @(posedge clk); while (!cfg_ch.ready);
            case (dmxcm_reg_t'(r))
                REG_BASE:     fixture_base = setting[r][SLOT_W-1:0];
                REG_TEMP_MIN: kelvin_lo = setting[r];
                REG_TEMP_MAX: kelvin_hi = setting[r];
                REG_PROFILE:  fixture_profile = setting[r][1:0];
                REG_DIM_OFF:  off_dim = setting[r][7:0];
                REG_TEMP_OFF: off_temp = setting[r][7:0];
                REG_HUE_OFF:  off_hue = setting[r][7:0];
                REG_SAT_OFF:  off_sat = setting[r][7:0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits for every expected beat, then lets a render that writes nothing
    // run to completion before anything else happens.
    task automatic settle();
        int waited;
        waited = 0;
        while (pending_reports.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_reports.size() != 0)
        begin
            $display("%0t: %0d expected result beats never arrived", $time,
                     pending_reports.size());
            failures += pending_reports.size();
            pending_reports.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        slot_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result beat: slot %0d level %0d final %0b", $time,
                         result_ch.slot_number, result_ch.slot_level, result_ch.final_flag);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result_ch.slot_number !== want.slot_number
                    || result_ch.slot_level !== want.slot_level
                    || result_ch.final_flag !== want.final_flag)
                begin
                    failures++;
                    $display("%0t: expected slot %0d level %0d final %0b, got slot %0d level %0d final %0b",
                             $time, want.slot_number, want.slot_level, want.final_flag,
                             result_ch.slot_number, result_ch.slot_level, result_ch.final_flag);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL dmx_fixture_channel_mapper");
        $finish;
    end

    initial
    begin
        directed_row_t directed_table [$];
        logic [15:0] setting [8];
        logic [15:0] spare;

        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.command     <= CMD_RENDER;
        item_ch.slot_index  <= '0;
        item_ch.slot_value  <= '0;
        item_ch.intensity   <= '0;
        item_ch.temp_kelvin <= '0;
        item_ch.hue_angle   <= '0;
        item_ch.saturation  <= '0;
        item_ch.use_hsi     <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_BASE;
        cfg_ch.data         <= '0;
        foreach (shadow_universe[i])
            shadow_universe[i] = '0;

        // Reset configuration: four-channel profile at slot 1, 2700 K to 6500 K.
        directed_table.push_back(table_row(pack_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1,
            slot_report(0, 0, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 7, 0, 0, 0, 0, 0, 0), 1,
            slot_report(7, 0, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 1023, 0, 0, 0, 0, 0, 0), 1,
            slot_report(1023, 0, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 513, 0, 0, 0, 0, 0, 0), 1,
            slot_report(513, 0, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_WRITE, 0, 255, 0, 0, 0, 0, 0), 0,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_WRITE, 513, 170, 0, 0, 0, 0, 0), 0,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_WRITE, 512, 255, 0, 0, 0, 0, 0), 1,
            slot_report(512, 255, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 512, 0, 0, 0, 0, 0, 0), 1,
            slot_report(512, 255, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_WRITE, 1, 0, 0, 0, 0, 0, 0), 1,
            slot_report(1, 0, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_IGNORED, 5, 99, 0, 0, 0, 0, 0), 0,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_RENDER, 0, 0, 0, 0, 0, 0, 0), 4,
            slot_report(1, 16, 0), slot_report(2, 0, 0), slot_report(3, 0, 0),
            slot_report(4, 128, 1)));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 65536, 0, 23040, 65536, 1), 4,
            slot_report(1, 48, 0), slot_report(2, 255, 0), slot_report(3, 255, 0),
            slot_report(4, 255, 1)));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 131071, 65535, 0, 0, 0), 4,
            slot_report(1, 16, 0), slot_report(2, 255, 0), slot_report(3, 255, 0),
            slot_report(4, 128, 1)));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 131071, 0, 0, 131071, 1), 4,
            slot_report(1, 48, 0), slot_report(2, 255, 0), slot_report(3, 0, 0),
            slot_report(4, 255, 1)));
        // Exactly half a level rounds up; a temperature at the minimum gives 0.
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 32768, 2700, 0, 0, 0), 4,
            slot_report(1, 16, 0), slot_report(2, 128, 0), slot_report(3, 0, 0),
            slot_report(4, 128, 1)));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 0, 6500, 0, 0, 0), 4,
            slot_report(1, 16, 0), slot_report(2, 0, 0), slot_report(3, 255, 0),
            slot_report(4, 128, 1)));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 40000, 4321, 7777, 99999, 1), -1,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 1, 2701, 1, 1, 0), -1,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(
            pack_item(CMD_RENDER, 0, 0, 65535, 3000, 16384, 65535, 1), -1,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 3, 0, 0, 0, 0, 0, 0), -1,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_WRITE, 300, 90, 0, 0, 0, 0, 0), 1,
            slot_report(300, 90, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 300, 0, 0, 0, 0, 0, 0), 1,
            slot_report(300, 90, 1), NO_REPORT, NO_REPORT, NO_REPORT));
        directed_table.push_back(table_row(pack_item(CMD_READ, 4, 0, 0, 0, 0, 0, 0), -1,
            NO_REPORT, NO_REPORT, NO_REPORT, NO_REPORT));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing pass after reset simply holds off the first beat.
        foreach (directed_table[i])
            send_item(directed_table[i].item, directed_table[i].n_known,
                      directed_table[i].known);
        item_ch.valid <= 1'b0;
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // Only the dimmer lands when the base is the last slot.
                    setting[REG_BASE] = 16'd512;
                    setting[REG_TEMP_MIN] = 16'd0;
                    setting[REG_TEMP_MAX] = 16'd65535;
                    setting[REG_PROFILE] = 16'(PROF_DIM_TEMP);
                    setting[REG_DIM_OFF] = 16'd0;
                    setting[REG_TEMP_OFF] = 16'd1;
                    setting[REG_HUE_OFF] = 16'd255;
                    setting[REG_SAT_OFF] = 16'd255;
                end
                1:
                begin
                    // Dimmer and temperature share a slot; the span is negative.
                    setting[REG_BASE] = 16'd1;
                    setting[REG_TEMP_MIN] = 16'd6500;
                    setting[REG_TEMP_MAX] = 16'd2700;
                    setting[REG_PROFILE] = 16'(PROF_CUSTOM);
                    setting[REG_DIM_OFF] = 16'd0;
                    setting[REG_TEMP_OFF] = 16'd0;
                    setting[REG_HUE_OFF] = 16'd254;
                    setting[REG_SAT_OFF] = 16'd255;
                end
                2:
                begin
                    // Base 0 puts the dimmer on the start code, which is dropped.
                    setting[REG_BASE] = 16'd0;
                    setting[REG_TEMP_MIN] = 16'd4000;
                    setting[REG_TEMP_MAX] = 16'd4000;
                    setting[REG_PROFILE] = 16'(PROF_CUSTOM);
                    setting[REG_DIM_OFF] = 16'd0;
                    setting[REG_TEMP_OFF] = 16'd255;
                    setting[REG_HUE_OFF] = 16'd1;
                    setting[REG_SAT_OFF] = 16'd1;
                end
                3:
                begin
                    setting[REG_BASE] = 16'd100;
                    setting[REG_TEMP_MIN] = 16'd2700;
                    setting[REG_TEMP_MAX] = 16'd6500;
                    setting[REG_PROFILE] = 16'(PROF_NONE);
                    setting[REG_DIM_OFF] = 16'd3;
                    setting[REG_TEMP_OFF] = 16'd2;
                    setting[REG_HUE_OFF] = 16'd1;
                    setting[REG_SAT_OFF] = 16'd0;
                end
                4:
                begin
                    setting[REG_BASE] = 16'd509;
                    setting[REG_TEMP_MIN] = 16'd1000;
                    setting[REG_TEMP_MAX] = 16'd1001;
                    setting[REG_PROFILE] = 16'(PROF_FOUR);
                    setting[REG_DIM_OFF] = 16'd255;
                    setting[REG_TEMP_OFF] = 16'd255;
                    setting[REG_HUE_OFF] = 16'd255;
                    setting[REG_SAT_OFF] = 16'd255;
                end
                default:
                begin
                    setting[REG_BASE] = 16'($urandom_range(0, 300));
                    if ($urandom_range(3) == 0)
                        setting[REG_BASE] = 16'($urandom_range(490, 512));
                    setting[REG_TEMP_MIN] = 16'($urandom());
                    setting[REG_TEMP_MAX] = 16'($urandom());
                    if ($urandom_range(3) != 0 && setting[REG_TEMP_MAX] < setting[REG_TEMP_MIN])
                    begin
                        spare = setting[REG_TEMP_MAX];
                        setting[REG_TEMP_MAX] = setting[REG_TEMP_MIN];
                        setting[REG_TEMP_MIN] = spare;
                    end
                    setting[REG_PROFILE] = 16'($urandom_range(0, 2));
                    for (int r = REG_DIM_OFF; r <= REG_SAT_OFF; r++)
                        setting[r] = ($urandom_range(3) == 0) ? 16'd255
                                                              : 16'($urandom_range(0, 7));
                end
            endcase
            program_fixture(setting);

            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase

            repeat (ITEMS_PER_PHASE)
                send_item(random_item(), -1, '0);
            item_ch.valid <= 1'b0;
            settle();
        end

        if (failures == 0)
            $display("PASS dmx_fixture_channel_mapper");
        else
            $display("FAIL dmx_fixture_channel_mapper");
        $finish;
    end

endmodule
